// ----- hdl/otr_pkg.sv -----
package otr_pkg;

  // Configuration register file, one field per register, 10 bits each.
  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] one_low_time;
    logic [9:0] zero_low_time;
    logic [9:0] long_release_time;
    logic [9:0] short_release_time;
    logic [9:0] read_low_time;
    logic [9:0] read_sample_time;
  } otr_cfg_t;

  localparam int unsigned REG_WIDTH = 10;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_ONE_LOW       = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd3;
  localparam logic [2:0] REG_LONG_RELEASE  = 3'd4;
  localparam logic [2:0] REG_SHORT_RELEASE = 3'd5;
  localparam logic [2:0] REG_READ_LOW      = 3'd6;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

  // Register reset values, microseconds.
  localparam logic [9:0] RST_RESET_LOW     = 10'd500;
  localparam logic [9:0] RST_PRESENCE_WAIT = 10'd200;
  localparam logic [9:0] RST_ONE_LOW       = 10'd3;
  localparam logic [9:0] RST_ZERO_LOW      = 10'd60;
  localparam logic [9:0] RST_LONG_RELEASE  = 10'd60;
  localparam logic [9:0] RST_SHORT_RELEASE = 10'd2;
  localparam logic [9:0] RST_READ_LOW      = 10'd2;
  localparam logic [9:0] RST_READ_SAMPLE   = 10'd12;

  // Sequencer phase codes. TX phases come in low/release pairs, one pair per byte.
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_R1_LOW    = 5'd1;
  localparam logic [4:0] PH_R1_WAIT   = 5'd2;
  localparam logic [4:0] PH_TX_FIRST  = 5'd3;
  localparam logic [4:0] PH_TX_LAST   = 5'd10;
  localparam logic [4:0] PH_GAP1      = 5'd11;
  localparam logic [4:0] PH_R2_LOW    = 5'd12;
  localparam logic [4:0] PH_R2_WAIT   = 5'd13;
  localparam logic [4:0] PH_GAP2      = 5'd14;
  localparam logic [4:0] PH_RD_LOW    = 5'd15;
  localparam logic [4:0] PH_RD_SAMPLE = 5'd16;
  localparam logic [4:0] PH_RD_TAIL   = 5'd17;

  // Bus commands.
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // Byte k of the transmit sequence.
  function automatic logic [7:0] cmd_byte(input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = CMD_SKIP_ROM;
      2'd1: b = CMD_CONVERT;
      2'd2: b = CMD_SKIP_ROM;
      default: b = CMD_READ_SCRATCH;
    endcase
    return b;
  endfunction

  // Phases during which the bus is pulled low.
  function automatic logic is_low_phase(input logic [4:0] p);
    logic [4:0] off;
    logic low;
    off = p - PH_TX_FIRST;
    if (p == PH_R1_LOW || p == PH_R2_LOW || p == PH_RD_LOW) begin
      low = 1'b1;
    end else if (p >= PH_TX_FIRST && p <= PH_TX_LAST) begin
      low = ~off[0];
    end else begin
      low = 1'b0;
    end
    return low;
  endfunction

endpackage

// ----- hdl/otr_in_if.sv -----
interface otr_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic line_level;

  modport source (output valid, output start_request, output line_level, input ready);
  modport sink (input valid, input start_request, input line_level, output ready);
endinterface

// ----- hdl/otr_out_if.sv -----
interface otr_out_if;
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic signed [6:0] temperature;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output temperature, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input temperature, output ready);
endinterface

// ----- hdl/otr_cfg.sv -----
module otr_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output otr_pkg::otr_cfg_t cfg
);

  logic [2:0] index;
  logic       wr_en;
  logic [9:0] wval;
  logic [9:0] rval;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[9:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time     <= otr_pkg::RST_RESET_LOW;
      cfg.presence_wait_time <= otr_pkg::RST_PRESENCE_WAIT;
      cfg.one_low_time       <= otr_pkg::RST_ONE_LOW;
      cfg.zero_low_time      <= otr_pkg::RST_ZERO_LOW;
      cfg.long_release_time  <= otr_pkg::RST_LONG_RELEASE;
      cfg.short_release_time <= otr_pkg::RST_SHORT_RELEASE;
      cfg.read_low_time      <= otr_pkg::RST_READ_LOW;
      cfg.read_sample_time   <= otr_pkg::RST_READ_SAMPLE;
    end else if (wr_en) begin
      unique case (index)
        otr_pkg::REG_RESET_LOW:     cfg.reset_low_time     <= wval;
        otr_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_time <= wval;
        otr_pkg::REG_ONE_LOW:       cfg.one_low_time       <= wval;
        otr_pkg::REG_ZERO_LOW:      cfg.zero_low_time      <= wval;
        otr_pkg::REG_LONG_RELEASE:  cfg.long_release_time  <= wval;
        otr_pkg::REG_SHORT_RELEASE: cfg.short_release_time <= wval;
        otr_pkg::REG_READ_LOW:      cfg.read_low_time      <= wval;
        otr_pkg::REG_READ_SAMPLE:   cfg.read_sample_time   <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      otr_pkg::REG_RESET_LOW:     rval = cfg.reset_low_time;
      otr_pkg::REG_PRESENCE_WAIT: rval = cfg.presence_wait_time;
      otr_pkg::REG_ONE_LOW:       rval = cfg.one_low_time;
      otr_pkg::REG_ZERO_LOW:      rval = cfg.zero_low_time;
      otr_pkg::REG_LONG_RELEASE:  rval = cfg.long_release_time;
      otr_pkg::REG_SHORT_RELEASE: rval = cfg.short_release_time;
      otr_pkg::REG_READ_LOW:      rval = cfg.read_low_time;
      default:                    rval = cfg.read_sample_time;
    endcase
  end

  assign prdata = {22'd0, rval};

endmodule

// ----- hdl/otr_seq.sv -----
module otr_seq #(
  parameter int unsigned GAP_TIME   = 100,
  parameter int unsigned TIME_WIDTH = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  otr_pkg::otr_cfg_t cfg,
  otr_in_if.sink            in_ch,
  otr_out_if.source         out_ch
);

  localparam int unsigned TW = TIME_WIDTH;

  // sequencer state
  logic [4:0]    phase;
  logic [TW-1:0] time_left;
  logic [2:0]    bit_position;
  logic [7:0]    command_shift;
  logic [7:0]    read_shift;
  logic [6:0]    result_hold;

  logic [4:0]    phase_next;
  logic [TW-1:0] time_left_next;
  logic [2:0]    bit_position_next;
  logic [7:0]    command_shift_next;
  logic [7:0]    read_shift_next;
  logic [6:0]    result_hold_next;
  logic          drive;
  logic          done;

  logic [4:0]    off;
  logic [1:0]    k;
  logic [1:0]    k_inc;
  logic [7:0]    cs_sh;
  logic [7:0]    nb;

  // result register
  logic          out_valid;
  logic          accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_next         = phase;
    time_left_next     = time_left;
    bit_position_next  = bit_position;
    command_shift_next = command_shift;
    read_shift_next    = read_shift;
    result_hold_next   = result_hold;
    drive              = 1'b0;
    done               = 1'b0;
    off                = 5'd0;
    k                  = 2'd0;
    k_inc              = 2'd0;
    cs_sh              = 8'd0;
    nb                 = 8'd0;

    if (phase > otr_pkg::PH_RD_TAIL) begin
      phase_next     = otr_pkg::PH_IDLE;
      time_left_next = '0;
    end
    if (phase_next == otr_pkg::PH_IDLE && in_ch.start_request) begin
      phase_next     = otr_pkg::PH_R1_LOW;
      time_left_next = TW'(cfg.reset_low_time);
    end

    if (phase_next != otr_pkg::PH_IDLE) begin
      drive = otr_pkg::is_low_phase(phase_next);
      if (time_left_next > TW'(1)) begin
        time_left_next = time_left_next - TW'(1);
      end else begin
        off   = phase_next - otr_pkg::PH_TX_FIRST;
        k     = off[2:1];
        k_inc = k + 2'd1;
        cs_sh = {1'b0, command_shift[7:1]};
        priority if (phase_next == otr_pkg::PH_R1_LOW) begin
          phase_next     = otr_pkg::PH_R1_WAIT;
          time_left_next = TW'(cfg.presence_wait_time);
        end else if (phase_next == otr_pkg::PH_R1_WAIT ||
                     phase_next == otr_pkg::PH_R2_WAIT) begin
          // open skip-ROM: byte 0 after the first reset, byte 2 after the second
          nb                 = otr_pkg::CMD_SKIP_ROM;
          command_shift_next = nb;
          bit_position_next  = 3'd0;
          phase_next         = (phase_next == otr_pkg::PH_R1_WAIT) ?
                               otr_pkg::PH_TX_FIRST : otr_pkg::PH_TX_FIRST + 5'd4;
          time_left_next     = nb[0] ? TW'(cfg.one_low_time) : TW'(cfg.zero_low_time);
        end else if (phase_next == otr_pkg::PH_GAP1) begin
          phase_next     = otr_pkg::PH_R2_LOW;
          time_left_next = TW'(cfg.reset_low_time);
        end else if (phase_next == otr_pkg::PH_R2_LOW) begin
          phase_next     = otr_pkg::PH_R2_WAIT;
          time_left_next = TW'(cfg.presence_wait_time);
        end else if (phase_next == otr_pkg::PH_GAP2) begin
          bit_position_next = 3'd0;
          phase_next        = otr_pkg::PH_RD_LOW;
          time_left_next    = TW'(cfg.read_low_time);
        end else if (phase_next >= otr_pkg::PH_TX_FIRST &&
                     phase_next <= otr_pkg::PH_TX_LAST) begin
          if (!off[0]) begin
            phase_next     = phase_next + 5'd1;
            time_left_next = command_shift[0] ? TW'(cfg.long_release_time) :
                                                TW'(cfg.short_release_time);
          end else begin
            command_shift_next = cs_sh;
            if (bit_position != 3'd7) begin
              bit_position_next = bit_position + 3'd1;
              phase_next        = phase_next - 5'd1;
              time_left_next    = cs_sh[0] ? TW'(cfg.one_low_time) : TW'(cfg.zero_low_time);
            end else if (k == 2'd1) begin
              bit_position_next = 3'd0;
              phase_next        = otr_pkg::PH_GAP1;
              time_left_next    = TW'(GAP_TIME);
            end else if (k == 2'd3) begin
              bit_position_next = 3'd0;
              phase_next        = otr_pkg::PH_GAP2;
              time_left_next    = TW'(GAP_TIME);
            end else begin
              nb                 = otr_pkg::cmd_byte(k_inc);
              command_shift_next = nb;
              bit_position_next  = 3'd0;
              phase_next         = otr_pkg::PH_TX_FIRST + {2'd0, k_inc, 1'b0};
              time_left_next     = nb[0] ? TW'(cfg.one_low_time) : TW'(cfg.zero_low_time);
            end
          end
        end else if (phase_next == otr_pkg::PH_RD_LOW) begin
          phase_next     = otr_pkg::PH_RD_SAMPLE;
          time_left_next = TW'(cfg.read_sample_time);
        end else if (phase_next == otr_pkg::PH_RD_SAMPLE) begin
          read_shift_next = {in_ch.line_level, read_shift[7:1]};
          phase_next      = otr_pkg::PH_RD_TAIL;
          time_left_next  = TW'(cfg.long_release_time);
        end else if (phase_next == otr_pkg::PH_RD_TAIL) begin
          if (bit_position != 3'd7) begin
            bit_position_next = bit_position + 3'd1;
            phase_next        = otr_pkg::PH_RD_LOW;
            time_left_next    = TW'(cfg.read_low_time);
          end else begin
            bit_position_next = 3'd0;
            result_hold_next  = read_shift[7:1];
            phase_next        = otr_pkg::PH_IDLE;
            time_left_next    = '0;
            done              = 1'b1;
          end
        end else begin
          phase_next     = otr_pkg::PH_IDLE;
          time_left_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= otr_pkg::PH_IDLE;
      time_left     <= '0;
      bit_position  <= 3'd0;
      command_shift <= 8'd0;
      read_shift    <= 8'd0;
      result_hold   <= 7'd0;
    end else if (accept) begin
      phase         <= phase_next;
      time_left     <= time_left_next;
      bit_position  <= bit_position_next;
      command_shift <= command_shift_next;
      read_shift    <= read_shift_next;
      result_hold   <= result_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.drive_low   <= drive;
      out_ch.busy_res    <= (phase_next != otr_pkg::PH_IDLE);
      out_ch.done_res    <= done;
      out_ch.temperature <= signed'(result_hold_next);
    end
  end

  assign out_ch.valid = out_valid;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done beat still reports busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.drive_low |-> out_ch.busy_res)
    else $error("bus driven low outside a sequence");

  a_idle_bitpos: assert property (@(posedge clk) disable iff (rst)
    phase == otr_pkg::PH_IDLE |-> bit_position == 3'd0)
    else $error("bit position not cleared in idle");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> out_ch.temperature == signed'(result_hold))
    else $error("done beat temperature differs from held result");

endmodule

// ----- hdl/onewire_temperature_read_master_top.sv -----
// One-wire temperature read master. Each input beat is one microsecond tick
// carrying start_request and the sampled line_level; each tick yields exactly
// one output beat with drive_low (pull the bus low this tick), busy_res,
// done_res and the last temperature in whole degrees (read byte >> 1, signed).
// A start tick in idle runs reset/presence, skip-ROM + convert, a gap, a second
// reset/presence, skip-ROM + read-scratchpad, a gap and eight read slots; the
// tick closing the last slot raises done_res. Starts while busy are ignored and
// presence is not checked. Segment lengths come from the APB registers (4*i
// byte addresses); write them only while idle. Rate: one tick per clock cycle,
// set by the sequencer step and the single output register; input ready drops
// only while a finished beat waits unaccepted downstream.
module onewire_temperature_read_master_top #(
  parameter int unsigned GAP_TIME   = 100,  // gap after each command pair, ticks
  parameter int unsigned TIME_WIDTH = 10    // width of the segment down-counter
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick channels
  otr_in_if.sink      in_ch,
  otr_out_if.source   out_ch
);

  // register file -> sequencer
  otr_pkg::otr_cfg_t cfg;

  otr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // bus sequencer: one step per accepted tick, result beat registered
  otr_seq #(
    .GAP_TIME   (GAP_TIME),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/sv/onewire_temperature_read_master_top_tb.sv -----
`timescale 1ns / 1ps

// Each input beat is one microsecond tick, and each tick yields exactly one
// output beat. The bus_tick_model class below mirrors the sequencer and holds
// the expected output beats. The output sink checks every accepted beat
// against the oldest pending one. Stimulus runs in phases. The register reset
// values are read back first. The block is configured only while idle, then
// fed random ticks with random start requests, then drained until the
// sequence in flight has finished.
module onewire_temperature_read_master_top_tb;

  localparam int unsigned GAP_TICKS     = 100;
  localparam int unsigned CNT_WIDTH     = 10;
  localparam int unsigned MAX_IDLE      = 13;
  localparam int unsigned SETTLE_CYCLES = 4;       // registered output, plus margin
  localparam int unsigned REPORT_LIMIT  = 10;
  // All phases together run about 2k ticks, 3.5k at most with the longest
  // drains. At worst a tick waits out an idle gap on each side plus the handshake.
  localparam longint unsigned CYCLE_LIMIT = 500_000;

  typedef struct {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [6:0] temperature;
  } tick_beat_t;

  // Sequencer mirror plus the store of output beats still to arrive.
  class bus_tick_model;
    otr_pkg::otr_cfg_t cfg;
    logic [4:0] ph;
    logic [9:0] remain;
    logic [2:0] bit_idx;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [6:0] degrees;
    tick_beat_t due_beats[$];
    int unsigned errors;
    int unsigned beats_seen;

    function new();
      cfg.reset_low_time     = otr_pkg::RST_RESET_LOW;
      cfg.presence_wait_time = otr_pkg::RST_PRESENCE_WAIT;
      cfg.one_low_time       = otr_pkg::RST_ONE_LOW;
      cfg.zero_low_time      = otr_pkg::RST_ZERO_LOW;
      cfg.long_release_time  = otr_pkg::RST_LONG_RELEASE;
      cfg.short_release_time = otr_pkg::RST_SHORT_RELEASE;
      cfg.read_low_time      = otr_pkg::RST_READ_LOW;
      cfg.read_sample_time   = otr_pkg::RST_READ_SAMPLE;
      ph         = otr_pkg::PH_IDLE;
      remain     = '0;
      bit_idx    = '0;
      tx_byte    = '0;
      rx_byte    = '0;
      degrees    = '0;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [9:0] v);
      case (idx)
        otr_pkg::REG_RESET_LOW:     cfg.reset_low_time     = v;
        otr_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_time = v;
        otr_pkg::REG_ONE_LOW:       cfg.one_low_time       = v;
        otr_pkg::REG_ZERO_LOW:      cfg.zero_low_time      = v;
        otr_pkg::REG_LONG_RELEASE:  cfg.long_release_time  = v;
        otr_pkg::REG_SHORT_RELEASE: cfg.short_release_time = v;
        otr_pkg::REG_READ_LOW:      cfg.read_low_time      = v;
        default:                    cfg.read_sample_time   = v;
      endcase
    endfunction

    // A load of zero still lasts one tick (the counter ends at <= 1).
    function void enter(logic [4:0] p, logic [CNT_WIDTH-1:0] t);
      ph     = p;
      remain = t;
    endfunction

    function void load_byte(int k);
      logic [7:0] b;
      case (k)
        0:       b = otr_pkg::CMD_SKIP_ROM;
        1:       b = otr_pkg::CMD_CONVERT;
        2:       b = otr_pkg::CMD_SKIP_ROM;
        default: b = otr_pkg::CMD_READ_SCRATCH;
      endcase
      tx_byte = b;
      bit_idx = '0;
      enter(otr_pkg::PH_TX_FIRST + 5'(2 * k), b[0] ? cfg.one_low_time : cfg.zero_low_time);
    endfunction

    function logic pulls_low(logic [4:0] p);
      case (p)
        otr_pkg::PH_R1_LOW, otr_pkg::PH_R2_LOW, otr_pkg::PH_RD_LOW: return 1'b1;
        default: begin
          if (p >= otr_pkg::PH_TX_FIRST && p <= otr_pkg::PH_TX_LAST)
            return ((int'(p) - int'(otr_pkg::PH_TX_FIRST)) % 2) == 0;
          return 1'b0;
        end
      endcase
    endfunction

    // Segment ran out: move on. Returns 1 on the tick that ends the sequence.
    function logic segment_end(logic line);
      int off;
      off = int'(ph) - int'(otr_pkg::PH_TX_FIRST);
      case (ph)
        otr_pkg::PH_R1_LOW:  enter(otr_pkg::PH_R1_WAIT, cfg.presence_wait_time);
        otr_pkg::PH_R1_WAIT: load_byte(0);
        otr_pkg::PH_GAP1:    enter(otr_pkg::PH_R2_LOW, cfg.reset_low_time);
        otr_pkg::PH_R2_LOW:  enter(otr_pkg::PH_R2_WAIT, cfg.presence_wait_time);
        otr_pkg::PH_R2_WAIT: load_byte(2);
        otr_pkg::PH_GAP2: begin
          bit_idx = '0;
          enter(otr_pkg::PH_RD_LOW, cfg.read_low_time);
        end
        otr_pkg::PH_RD_LOW:  enter(otr_pkg::PH_RD_SAMPLE, cfg.read_sample_time);
        otr_pkg::PH_RD_SAMPLE: begin
          rx_byte = {line, rx_byte[7:1]};
          enter(otr_pkg::PH_RD_TAIL, cfg.long_release_time);
        end
        otr_pkg::PH_RD_TAIL: begin
          if (bit_idx != 3'd7) begin
            bit_idx = bit_idx + 3'd1;
            enter(otr_pkg::PH_RD_LOW, cfg.read_low_time);
          end else begin
            bit_idx = '0;
            degrees = rx_byte[7:1];
            enter(otr_pkg::PH_IDLE, '0);
            return 1'b1;
          end
        end
        default: begin
          if (ph >= otr_pkg::PH_TX_FIRST && ph <= otr_pkg::PH_TX_LAST) begin
            if (off % 2 == 0) begin
              enter(ph + 5'd1, tx_byte[0] ? cfg.long_release_time : cfg.short_release_time);
            end else begin
              tx_byte = tx_byte >> 1;
              if (bit_idx != 3'd7) begin
                bit_idx = bit_idx + 3'd1;
                enter(ph - 5'd1, tx_byte[0] ? cfg.one_low_time : cfg.zero_low_time);
              end else if (off / 2 == 1) begin
                bit_idx = '0;
                enter(otr_pkg::PH_GAP1, CNT_WIDTH'(GAP_TICKS));
              end else if (off / 2 == 3) begin
                bit_idx = '0;
                enter(otr_pkg::PH_GAP2, CNT_WIDTH'(GAP_TICKS));
              end else begin
                load_byte(off / 2 + 1);
              end
            end
          end else begin
            enter(otr_pkg::PH_IDLE, '0);
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void note_tick(logic start, logic line);
      tick_beat_t b;
      b.drive_low = 1'b0;
      b.done      = 1'b0;
      if (ph > otr_pkg::PH_RD_TAIL) enter(otr_pkg::PH_IDLE, '0);
      if (ph == otr_pkg::PH_IDLE && start) enter(otr_pkg::PH_R1_LOW, cfg.reset_low_time);
      if (ph != otr_pkg::PH_IDLE) begin
        b.drive_low = pulls_low(ph);
        if (remain > 1) remain = remain - 1'b1;
        else b.done = segment_end(line);
      end
      b.busy        = (ph != otr_pkg::PH_IDLE);
      b.temperature = degrees;
      due_beats.push_back(b);
    endfunction

    function void check_beat(tick_beat_t got);
      tick_beat_t want;
      beats_seen++;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("output beat %0d arrived with no tick pending", beats_seen);
        return;
      end
      want = due_beats.pop_front();
      if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
          got.done !== want.done || got.temperature !== want.temperature) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("beat %0d: expected drive_low=%0b busy=%0b done=%0b temp=%0d, got %0b %0b %0b %0d",
                   beats_seen, want.drive_low, want.busy, want.done,
                   $signed(want.temperature), got.drive_low, got.busy, got.done,
                   $signed(got.temperature));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  otr_in_if  in_ch();
  otr_out_if out_ch();

  onewire_temperature_read_master_top #(
    .GAP_TIME  (GAP_TICKS),
    .TIME_WIDTH(CNT_WIDTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bus_tick_model model = new();

  // Idle knobs, changed per phase; both sides draw from the same one.
  int unsigned idle_pct;
  int unsigned start_pct;
  // Byte the simulated sensor returns in the read slots of the current sequence.
  // Sign extremes and other edge patterns go first, random bytes after.
  logic [7:0] read_pattern;
  logic [7:0] fixed_patterns[$] = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hAA};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_idle();
    return ($urandom_range(0, 99) < idle_pct) ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  function automatic otr_pkg::otr_cfg_t random_cfg(int unsigned hi);
    otr_pkg::otr_cfg_t c;
    c.reset_low_time     = 10'($urandom_range(1, hi));
    c.presence_wait_time = 10'($urandom_range(1, hi));
    c.one_low_time       = 10'($urandom_range(1, hi));
    c.zero_low_time      = 10'($urandom_range(1, hi));
    c.long_release_time  = 10'($urandom_range(1, hi));
    c.short_release_time = 10'($urandom_range(1, hi));
    c.read_low_time      = 10'($urandom_range(1, hi));
    c.read_sample_time   = 10'($urandom_range(1, hi));
    return c;
  endfunction

  // APB write: setup cycle, then access until pready.
  // Leaves psel high, so back-to-back writes need no extra cycle.
  task automatic reg_write(logic [2:0] idx, logic [9:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model.write_reg(idx, v);
  endtask

  // APB read of one register, compared against the expected value.
  task automatic reg_check(logic [2:0] idx, logic [9:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== 32'(want)) begin
      model.errors++;
      if (model.errors <= REPORT_LIMIT)
        $display("register %0d: expected %0d, got %0d", idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(otr_pkg::otr_cfg_t c);
    reg_write(otr_pkg::REG_RESET_LOW,     c.reset_low_time);
    reg_write(otr_pkg::REG_PRESENCE_WAIT, c.presence_wait_time);
    reg_write(otr_pkg::REG_ONE_LOW,       c.one_low_time);
    reg_write(otr_pkg::REG_ZERO_LOW,      c.zero_low_time);
    reg_write(otr_pkg::REG_LONG_RELEASE,  c.long_release_time);
    reg_write(otr_pkg::REG_SHORT_RELEASE, c.short_release_time);
    reg_write(otr_pkg::REG_READ_LOW,      c.read_low_time);
    reg_write(otr_pkg::REG_READ_SAMPLE,   c.read_sample_time);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One tick beat. On a sample tick the line carries the current pattern bit;
  // on every other tick the line level is random.
  // valid stays high across back-to-back beats.
  task automatic send_tick(logic start);
    int unsigned gap;
    logic        line;
    logic        was_idle;
    gap = draw_idle();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line     = (model.ph == otr_pkg::PH_RD_SAMPLE) ? read_pattern[model.bit_idx]
                                                   : 1'($urandom_range(0, 1));
    was_idle = (model.ph == otr_pkg::PH_IDLE);
    in_ch.valid         <= 1'b1;
    in_ch.start_request <= start;
    in_ch.line_level    <= line;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model.note_tick(start, line);
    // A new sequence just started: choose what the sensor will return.
    if (was_idle && model.ph != otr_pkg::PH_IDLE)
      read_pattern = (fixed_patterns.size() != 0) ? fixed_patterns.pop_front()
                                                  : 8'($urandom);
  endtask

  // Finish the sequence in flight, then wait until every beat is back.
  task automatic drain_and_settle();
    while (model.ph != otr_pkg::PH_IDLE) send_tick(1'b0);
    in_ch.valid <= 1'b0;
    while (model.due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(otr_pkg::otr_cfg_t c, int unsigned n_ticks, int unsigned idle,
                           int unsigned starts);
    cfg_write(c);
    idle_pct  = idle;
    start_pct = starts;
    repeat (n_ticks) send_tick($urandom_range(0, 99) < start_pct);
    drain_and_settle();
  endtask

  // Output side: random stalls, then every accepted beat is checked.
  initial begin : result_sink
    tick_beat_t  got;
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = draw_idle();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.drive_low   = out_ch.drive_low;
      got.busy        = out_ch.busy_res;
      got.done        = out_ch.done_res;
      got.temperature = out_ch.temperature;
      model.check_beat(got);
    end
  end

  initial begin : watchdog
    longint unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    otr_pkg::otr_cfg_t c;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.start_request = 1'b0;
    in_ch.line_level    = 1'b0;
    idle_pct            = 20;
    start_pct           = 0;
    read_pattern        = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values of every register.
    reg_check(otr_pkg::REG_RESET_LOW,     otr_pkg::RST_RESET_LOW);
    reg_check(otr_pkg::REG_PRESENCE_WAIT, otr_pkg::RST_PRESENCE_WAIT);
    reg_check(otr_pkg::REG_ONE_LOW,       otr_pkg::RST_ONE_LOW);
    reg_check(otr_pkg::REG_ZERO_LOW,      otr_pkg::RST_ZERO_LOW);
    reg_check(otr_pkg::REG_LONG_RELEASE,  otr_pkg::RST_LONG_RELEASE);
    reg_check(otr_pkg::REG_SHORT_RELEASE, otr_pkg::RST_SHORT_RELEASE);
    reg_check(otr_pkg::REG_READ_LOW,      otr_pkg::RST_READ_LOW);
    reg_check(otr_pkg::REG_READ_SAMPLE,   otr_pkg::RST_READ_SAMPLE);

    // Directed: idle ticks, a start from idle, starts while busy ignored.
    // Runs on short timing, with sensor byte 0x80 (most negative result).
    c = random_cfg(2);
    cfg_write(c);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_and_settle();

    // Shortest timing everywhere.
    c = random_cfg(1);
    run_phase(c, 250, 30, 10);
    // Small random timings: heavy stalls, no stalls with frequent starts.
    c = random_cfg(4);
    run_phase(c, 200, 50, 15);
    c = random_cfg(4);
    run_phase(c, 150, 0, 40);
    // Somewhat longer segments.
    c = random_cfg(8);
    run_phase(c, 100, 25, 10);

    if (model.errors == 0 && model.due_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
